>>> rtl/wah_bitmap_weighted_field_count_assert.svh
// Assertion macros used by the checker of this block.
`ifndef WAH_BITMAP_WEIGHTED_FIELD_COUNT_ASSERT_SVH
`define WAH_BITMAP_WEIGHTED_FIELD_COUNT_ASSERT_SVH

// ante in one cycle implies cons in the next cycle
`define WBFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbfc assertion failed");

// ante implies cons in the same cycle
`define WBFC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbfc assertion failed");

`endif

>>> rtl/wbfc_pkg.sv
package wbfc_pkg;

    localparam int MAX_FIELDS_DEF   = 4096;
    localparam int COUNTER_BITS_DEF = 32;

    localparam int FC_W     = 13;   // field_count register
    localparam int WORD_W   = 32;
    localparam int WEIGHT_W = 32;
    localparam int IDX_W    = 12;
    localparam int OUT_W    = 32;

    localparam int GROUP_BITS    = 31;
    localparam int GROUP_SHIFT   = 5;     // 31 = 2^5 - 1
    localparam int RUN_W         = 30;
    localparam int SPAN_W        = RUN_W + GROUP_SHIFT;
    localparam int WORD_KIND_BIT = 31;
    localparam int VALUE_BIT     = 30;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_ADD   = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

    localparam logic [FC_W-1:0] FIELD_COUNT_RESET = 13'd4096;

endpackage

>>> rtl/wbfc_ram.sv
module wbfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/wah_bitmap_weighted_field_count.sv
// WAH bitmap decoder with one weighted counter per field, held in a single-port-write,
// single-port-read RAM and updated by read-modify-write, one counter per cycle. in_ready is
// high only while idle. An add word is ignored when its start field is at or past the field
// limit; a zero fill skips its run_length*31 fields without RAM access, a literal word walks
// its 31 bits and a one fill walks run_length*31 fields, both stopping early at the field
// limit; a read waits on the output register while a held result is not taken; a clear
// zeroes all MAX_FIELDS counters. After reset the block sweeps the counter RAM to zero before
// it accepts its first item; configuration writes are taken at any time.
module wah_bitmap_weighted_field_count #(
    parameter int MAX_FIELDS   = wbfc_pkg::MAX_FIELDS_DEF,
    parameter int COUNTER_BITS = wbfc_pkg::COUNTER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wbfc_pkg::FC_W-1:0]      field_count,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  wbfc_pkg::cmd_t                 cmd,
    input  logic [wbfc_pkg::WORD_W-1:0]    wah_word,
    input  logic                           start_bitmap,
    input  logic [wbfc_pkg::WEIGHT_W-1:0]  weight,
    input  logic [wbfc_pkg::IDX_W-1:0]     read_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [wbfc_pkg::OUT_W-1:0]     count_value
);

    import wbfc_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FIELDS);
    localparam int POS_W  = $clog2(MAX_FIELDS + 1);
    localparam int CMP_W  = (POS_W > FC_W) ? POS_W : FC_W;
    localparam int ICMP_W = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam int SUM_W  = SPAN_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_SKIP  = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_RDATA = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [FC_W-1:0]         fc_reg;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [SPAN_W-1:0]       rem_reg, rem_next;
    logic [GROUP_BITS-1:0]   bits_reg, bits_next;
    logic                    fill_reg, fill_next;
    logic [WEIGHT_W-1:0]     weight_reg, weight_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic                    pend_reg, pend_next;
    logic [ADDR_W-1:0]       pend_addr_reg, pend_addr_next;
    logic                    rd_zero_reg, rd_zero_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        count_value_reg, count_value_next;

    logic [CMP_W-1:0]        fc_ext, max_ext, limit_cmp;
    logic [POS_W-1:0]        limit;
    logic [POS_W-1:0]        pos0;
    logic [SPAN_W-1:0]       span;
    logic [SUM_W-1:0]        skip_sum;
    logic                    accept;
    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [COUNTER_BITS-1:0] ram_wdata, ram_rdata;

    assign fc_ext    = CMP_W'(fc_reg);
    assign max_ext   = CMP_W'(MAX_FIELDS);
    assign limit_cmp = (fc_ext < max_ext) ? fc_ext : max_ext;
    assign limit     = POS_W'(limit_cmp);

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign count_value = count_value_reg;

    assign pos0     = start_bitmap ? '0 : pos_reg;
    assign span     = (SPAN_W'(wah_word[RUN_W-1:0]) << GROUP_SHIFT)
                    - SPAN_W'(wah_word[RUN_W-1:0]);
    assign skip_sum = SUM_W'(pos_reg) + SUM_W'(rem_reg);

    // pending write finishes the read-modify-write issued in the previous cycle
    assign ram_we    = pend_reg || (state_reg == ST_CLEAR);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : pend_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0
                     : ram_rdata + COUNTER_BITS'(weight_reg);

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        rem_next         = rem_reg;
        bits_next        = bits_reg;
        fill_next        = fill_reg;
        weight_next      = weight_reg;
        clr_next         = clr_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        rd_zero_next     = rd_zero_reg;
        out_valid_next   = out_valid_reg;
        count_value_next = count_value_reg;
        ram_re           = 1'b0;
        ram_raddr        = ADDR_W'(pos_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_ADD:
                        begin
                            pos_next    = pos0;
                            weight_next = weight;
                            if (pos0 < limit)
                            begin
                                if (wah_word[WORD_KIND_BIT])
                                begin
                                    rem_next   = span;
                                    fill_next  = 1'b1;
                                    state_next = wah_word[VALUE_BIT] ? ST_WALK : ST_SKIP;
                                end
                                else
                                begin
                                    rem_next   = SPAN_W'(GROUP_BITS);
                                    bits_next  = wah_word[GROUP_BITS-1:0];
                                    fill_next  = 1'b0;
                                    state_next = ST_WALK;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = ADDR_W'(read_index);
                            rd_zero_next = !(ICMP_W'(read_index) < ICMP_W'(MAX_FIELDS));
                            state_next   = ST_RDATA;
                        end
                        CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MAX_FIELDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SKIP:
            begin
                pos_next   = (skip_sum >= SUM_W'(limit)) ? limit : POS_W'(skip_sum);
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if ((rem_reg == '0) || (pos_reg >= limit))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // one field per cycle, bit 30 of a literal is the lowest field
                    ram_re         = fill_reg || bits_reg[GROUP_BITS-1];
                    pend_next      = ram_re;
                    pend_addr_next = ADDR_W'(pos_reg);
                    pos_next       = pos_reg + POS_W'(1);
                    rem_next       = rem_reg - SPAN_W'(1);
                    bits_next      = bits_reg << 1;
                end
            end
            ST_RDATA:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    count_value_next = rd_zero_reg ? '0 : OUT_W'(ram_rdata);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            fc_reg        <= FIELD_COUNT_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                fc_reg <= field_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        bits_reg        <= bits_next;
        fill_reg        <= fill_next;
        weight_reg      <= weight_next;
        pend_addr_reg   <= pend_addr_next;
        rd_zero_reg     <= rd_zero_next;
        count_value_reg <= count_value_next;
    end

    wbfc_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (MAX_FIELDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/wbfc_checker.sv
`include "wah_bitmap_weighted_field_count_assert.svh"

module wbfc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [wbfc_pkg::FC_W-1:0]      field_count,
    input logic                           in_valid,
    input logic                           in_ready,
    input wbfc_pkg::cmd_t                 cmd,
    input logic [wbfc_pkg::WORD_W-1:0]    wah_word,
    input logic                           start_bitmap,
    input logic [wbfc_pkg::WEIGHT_W-1:0]  weight,
    input logic [wbfc_pkg::IDX_W-1:0]     read_index,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [wbfc_pkg::OUT_W-1:0]     count_value
);

    import wbfc_pkg::*;

    // a stalled result holds its value
    `WBFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(count_value))

    // a clear item sweeps the counters before the next item
    `WBFC_ASSERT_NEXT(a_clear_busy, in_valid && in_ready && (cmd == CMD_CLEAR), !in_ready)

    // a read item occupies the block until its result is loaded
    `WBFC_ASSERT_NEXT(a_read_busy, in_valid && in_ready && (cmd == CMD_READ), !in_ready)

    // configuration is always taken
    `WBFC_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind wah_bitmap_weighted_field_count wbfc_checker u_wbfc_checker (.*);
